[src/ps2m_pkg.sv]
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2m_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int CNT_OUT_W         = 32;
    localparam int NUM_BUTTONS       = 3;

    // Pending event mask: presses in the low bits, motion, then releases.
    localparam int MASK_W      = 2 * NUM_BUTTONS + 1;
    localparam int MOTION_SLOT = NUM_BUTTONS;

    // Bit positions in the first byte of a packet
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int XOVF_BIT  = 6;
    localparam int YOVF_BIT  = 7;

    // Byte position within a packet
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LAST   = 2'd2;

    // Event kinds
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_MOTION  = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
    } t_batch;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] packets;
        logic [CNT_OUT_W-1:0] resyncs;
        logic [CNT_OUT_W-1:0] overflows;
        logic [CNT_OUT_W-1:0] motions;
        logic [CNT_OUT_W-1:0] abs_dx;
        logic [CNT_OUT_W-1:0] abs_dy;
    } t_counts;

endpackage

[src/ps2m_decode.sv]
// Packet framing, button/motion decode and statistics counters.
module ps2m_decode #(
    parameter int COUNTER_WIDTH = ps2m_pkg::COUNTER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output ps2m_pkg::t_batch o_batch,
    output ps2m_pkg::t_counts o_counts
);
    import ps2m_pkg::*;

    logic [1:0]               r_pos;
    logic [NUM_BUTTONS-1:0]   r_prior;
    logic [7:0]               r_held0;
    logic [7:0]               r_held1;
    logic [COUNTER_WIDTH-1:0] r_packets, r_resyncs, r_overflows;
    logic [COUNTER_WIDTH-1:0] r_motions, r_abs_dx, r_abs_dy;

    logic                   resync;
    logic                   complete;
    logic [NUM_BUTTONS-1:0] buttons;
    logic [NUM_BUTTONS-1:0] changed;
    logic                   x_ovf;
    logic                   y_ovf;
    logic [9:0]             dx_ext;
    logic [9:0]             ay_ext;
    logic [9:0]             dy_val;
    logic [9:0]             abs_dx;
    logic [9:0]             abs_dy;
    logic                   moving;

    always_comb begin
        resync   = (r_pos == POS_FIRST) && !i_byte[SYNC_BIT];
        complete = (r_pos == POS_LAST);
        buttons  = r_held0[NUM_BUTTONS-1:0];
        changed  = buttons ^ r_prior;
        x_ovf    = r_held0[XOVF_BIT];
        y_ovf    = r_held0[YOVF_BIT];

        dx_ext = x_ovf ? 10'd0 : {r_held0[XSIGN_BIT], r_held0[XSIGN_BIT], r_held1};
        ay_ext = {r_held0[YSIGN_BIT], r_held0[YSIGN_BIT], i_byte};
        // dy is flipped so that downward motion is positive
        dy_val = y_ovf ? 10'd0 : (~ay_ext + 10'd1);

        abs_dx = dx_ext[9] ? (~dx_ext + 10'd1) : dx_ext;
        abs_dy = dy_val[9] ? (~dy_val + 10'd1) : dy_val;
        moving = (dx_ext != 10'd0) || (dy_val != 10'd0);

        o_batch.mask = complete ? {changed & ~buttons, moving, changed & buttons}
                                : '0;
        o_batch.dx   = dx_ext[8:0];
        o_batch.dy   = dy_val;

        o_counts.packets   = CNT_OUT_W'(r_packets);
        o_counts.resyncs   = CNT_OUT_W'(r_resyncs);
        o_counts.overflows = CNT_OUT_W'(r_overflows);
        o_counts.motions   = CNT_OUT_W'(r_motions);
        o_counts.abs_dx    = CNT_OUT_W'(r_abs_dx);
        o_counts.abs_dy    = CNT_OUT_W'(r_abs_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_FIRST;
            r_prior     <= '0;
            r_packets   <= '0;
            r_resyncs   <= '0;
            r_overflows <= '0;
            r_motions   <= '0;
            r_abs_dx    <= '0;
            r_abs_dy    <= '0;
        end else if (i_take) begin
            case (r_pos)
                POS_FIRST: begin
                    if (resync) begin
                        r_resyncs <= r_resyncs + COUNTER_WIDTH'(1);
                    end else begin
                        r_pos <= POS_SECOND;
                    end
                end
                POS_SECOND: begin
                    r_pos <= POS_LAST;
                end
                default: begin
                    r_pos       <= POS_FIRST;
                    r_prior     <= buttons;
                    r_packets   <= r_packets + COUNTER_WIDTH'(1);
                    r_overflows <= r_overflows + COUNTER_WIDTH'(x_ovf)
                                               + COUNTER_WIDTH'(y_ovf);
                    if (moving) begin
                        r_motions <= r_motions + COUNTER_WIDTH'(1);
                        r_abs_dx  <= r_abs_dx + COUNTER_WIDTH'(abs_dx);
                        r_abs_dy  <= r_abs_dy + COUNTER_WIDTH'(abs_dy);
                    end
                end
            endcase
        end
    end

    // held bytes are payload: written before any read, no reset
    always_ff @(posedge i_clk) begin
        if (i_take && r_pos == POS_FIRST && !resync) begin
            r_held0 <= i_byte;
        end
        if (i_take && r_pos == POS_SECOND) begin
            r_held1 <= i_byte;
        end
    end

endmodule

[src/ps2m_emit.sv]
// Event serialiser: pending event mask and the output register.
module ps2m_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ps2m_pkg::t_batch  i_batch,
    input  ps2m_pkg::t_counts i_counts,
    input  logic              i_stall,
    output logic              o_can_load,
    output logic              o_valid,
    output logic [1:0]        o_event_kind,
    output logic [1:0]        o_button_index,
    output logic signed [8:0] o_motion_dx,
    output logic signed [9:0] o_motion_dy,
    output logic              o_last_of_run,
    output ps2m_pkg::t_counts o_counts
);
    import ps2m_pkg::*;

    logic [MASK_W-1:0] r_pend;
    logic signed [8:0] r_dx;
    logic signed [9:0] r_dy;
    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [1:0]        r_button;
    logic signed [8:0] r_out_dx;
    logic signed [9:0] r_out_dy;
    logic              r_last;
    t_counts           r_counts;

    logic [MASK_W-1:0] low_bit;
    logic [2:0]        slot;
    logic              one_left;
    logic              out_free;
    logic              pop;
    logic [1:0]        n_kind;
    logic [1:0]        n_button;

    always_comb begin
        low_bit  = r_pend & (~r_pend + MASK_W'(1));
        one_left = (r_pend & (r_pend - MASK_W'(1))) == '0;
        slot     = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (low_bit[i]) begin
                slot = 3'(i);
            end
        end
        out_free   = !r_out_valid || !i_stall;
        pop        = out_free && (r_pend != '0);
        o_can_load = (r_pend == '0) || (pop && one_left);

        if (slot < 3'(MOTION_SLOT)) begin
            n_kind   = EV_PRESS;
            n_button = slot[1:0];
        end else if (slot == 3'(MOTION_SLOT)) begin
            n_kind   = EV_MOTION;
            n_button = '0;
        end else begin
            n_kind   = EV_RELEASE;
            n_button = 2'(slot - 3'(MOTION_SLOT + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_pend <= i_batch.mask;
            end else if (pop) begin
                r_pend <= r_pend & ~low_bit;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dx <= i_batch.dx;
            r_dy <= i_batch.dy;
        end
        if (pop) begin
            r_kind   <= n_kind;
            r_button <= n_button;
            r_out_dx <= (n_kind == EV_MOTION) ? r_dx : '0;
            r_out_dy <= (n_kind == EV_MOTION) ? r_dy : '0;
            r_last   <= one_left;
            // counters cannot move while events are pending
            r_counts <= i_counts;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_button_index = r_button;
    assign o_motion_dx    = r_out_dx;
    assign o_motion_dy    = r_out_dy;
    assign o_last_of_run  = r_last;
    assign o_counts       = r_counts;

endmodule

[src/ps2_mouse_packet_decoder.sv]
// Top level of the PS/2 mouse three-byte packet decoder.
//
// Input channel: one auxiliary-port byte per beat on i_data_byte, taken when
// i_valid is high and o_stall is low. Bytes are framed into three-byte
// packets; a first byte without the always-one bit is dropped as a resync.
// Output channel: one event per beat (press, motion, release) with the
// statistics counters as they stand after the causing byte; o_last_of_run
// marks the final event of a byte. Bytes causing no event give no beat.
// A byte waits in the input register, its events in the pending event mask,
// and each event leaves from the output register. Throughput: one byte per
// cycle while no events are pending; other bytes wait in the input register
// while a packet-closing byte's events (at most four) leave the serialiser.
// Reset (synchronous, active low) clears framing, button history, counters
// and all valid flags. When the receiver stalls, the output beat holds, the
// serialiser stops, and o_stall rises while the full input register is blocked.
module ps2_mouse_packet_decoder #(
    parameter int COUNTER_WIDTH = ps2m_pkg::COUNTER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic [1:0]  o_button_index,
    output logic signed [8:0] o_motion_dx,
    output logic signed [9:0] o_motion_dy,
    output logic        o_last_of_run,
    output logic [ps2m_pkg::CNT_OUT_W-1:0] o_packets_seen,
    output logic [ps2m_pkg::CNT_OUT_W-1:0] o_resyncs_seen,
    output logic [ps2m_pkg::CNT_OUT_W-1:0] o_overflows_seen,
    output logic [ps2m_pkg::CNT_OUT_W-1:0] o_motions_seen,
    output logic [ps2m_pkg::CNT_OUT_W-1:0] o_abs_dx_total,
    output logic [ps2m_pkg::CNT_OUT_W-1:0] o_abs_dy_total
);
    import ps2m_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       take;
    logic       in_ready;
    logic       can_load;
    t_batch     batch;
    t_counts    counts;
    t_counts    out_counts;

    assign take     = r_in_valid && can_load;
    assign in_ready = !r_in_valid || take;
    assign o_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    ps2m_decode #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (r_in_byte),
        .o_batch  (batch),
        .o_counts (counts)
    );

    ps2m_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (take),
        .i_batch        (batch),
        .i_counts       (counts),
        .i_stall        (i_stall),
        .o_can_load     (can_load),
        .o_valid        (o_valid),
        .o_event_kind   (o_event_kind),
        .o_button_index (o_button_index),
        .o_motion_dx    (o_motion_dx),
        .o_motion_dy    (o_motion_dy),
        .o_last_of_run  (o_last_of_run),
        .o_counts       (out_counts)
    );

    assign o_packets_seen   = out_counts.packets;
    assign o_resyncs_seen   = out_counts.resyncs;
    assign o_overflows_seen = out_counts.overflows;
    assign o_motions_seen   = out_counts.motions;
    assign o_abs_dx_total   = out_counts.abs_dx;
    assign o_abs_dy_total   = out_counts.abs_dy;

endmodule

[src/ps2m_checker.sv]
// Port-level checks for the PS/2 mouse packet decoder, bound to the top level.
module ps2m_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_event_kind,
    input logic [1:0]  o_button_index,
    input logic signed [8:0] o_motion_dx,
    input logic signed [9:0] o_motion_dy,
    input logic        o_last_of_run,
    input logic [ps2m_pkg::CNT_OUT_W-1:0] o_packets_seen
);
    import ps2m_pkg::*;

    // a motion beat always carries some movement
    a_motion_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == EV_MOTION |-> o_motion_dx != 0 || o_motion_dy != 0)
        else $error("motion beat with zero deltas");

    // button beats name a real button and carry no motion
    a_button_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == EV_PRESS || o_event_kind == EV_RELEASE)
        |-> o_button_index < 2'd3 && o_motion_dx == 0 && o_motion_dy == 0)
        else $error("malformed button beat");

    a_no_empty_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_event_kind != EV_NONE)
        else $error("beat with no event");

    // the rest of a run follows at once with the same counter snapshot
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid && $stable(o_packets_seen))
        else $error("event run broken or counters moved mid-run");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_kind))
        else $error("stalled beat changed");

endmodule

bind ps2_mouse_packet_decoder ps2m_checker u_ps2m_checker (.*);
